// ----- design/atclr_pkg.sv -----
package atclr_pkg;

    // Sizes
    localparam int LINE_BYTES = 64;
    localparam int NAME_SLOTS = 6;
    localparam int SLOT_REGS  = 6;
    localparam int NAME_BYTES = 8;
    localparam int CFG_W      = 8 * NAME_BYTES;
    localparam int CNT_W      = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int NB_W       = $clog2(NAME_BYTES);
    localparam int LEN_W      = $clog2(NAME_BYTES + 1);
    localparam int IDX_W      = $clog2(SLOT_REGS);
    localparam int SLOT_W     = 3;

    localparam logic [CFG_W-1:0] SLOT0_RESET = 64'h0000_0000_0000_5441;

    // Control characters
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_UNKNOWN  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVF,
        S_PROC,
        S_END_CMP,
        S_HEAD,
        S_ARG_RD,
        S_ARG_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take_byte;
        logic clear_line;
        logic write_byte;
        logic back_space;
        logic rd_last;
        logic load_cmp;
        logic rd_arg;
        logic emit_ovf;
        logic emit_unknown;
        logic emit_head;
        logic emit_arg;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic is_bs;
        logic is_lf;
        logic out_free;
        logic no_match;
        logic hdr_last;
        logic arg_last;
    } t_sts;

endpackage

// ----- design/at_command_line_recognizer.sv -----
// Channel   Dir  Transfer qualifier              Payload
// s_axis    in   s_axis_tvalid & s_axis_tready  tdata: rx_byte
// m_axis    out  m_axis_tvalid & m_axis_tready  tdata: slot_index, arg_byte; tuser: status,
//                                               arg_valid; tlast: last
// cfg       in   i_cfg_we                        index: name slot 0..5, data: 64-bit name
//
// An ordinary byte is first taken from the transfer, then written to the line store.
// A byte arriving on a full line first passes S_OVF, which emits the overflow result and clears the line.
// A line feed passes S_PROC, S_END_CMP and S_HEAD to the header result, and each argument byte
// then passes S_ARG_RD and S_ARG_OUT, since the line store has a single registered read port.
// Synchronous active-low reset clears the line and loads the default name slots.
// A stalled result output holds the block only when a new result must be loaded.
module at_command_line_recognizer
    import atclr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [2:0] slot_index, [10:3] arg_byte, rest zero
    output logic [2:0]        m_axis_tuser,   // [1:0] status, [2] arg_valid
    output logic              m_axis_tlast,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd              w_cmd;
    t_sts              w_sts;
    t_status           w_status;
    logic [SLOT_W-1:0] w_slot_index;
    logic [7:0]        w_arg_byte;
    logic              w_arg_valid;

    atclr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    atclr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (s_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_m_tready   (m_axis_tready),
        .o_m_tvalid   (m_axis_tvalid),
        .o_status     (w_status),
        .o_slot_index (w_slot_index),
        .o_arg_byte   (w_arg_byte),
        .o_arg_valid  (w_arg_valid),
        .o_last       (m_axis_tlast)
    );

    // Pack result fields
    assign m_axis_tdata = {5'b0, w_arg_byte, w_slot_index};
    assign m_axis_tuser = {w_arg_valid, w_status};

endmodule

// ----- design/atclr_ctrl.sv -----
module atclr_ctrl
    import atclr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.take_byte = 1'b1;
                    n_state = i_sts.full ? S_OVF : S_PROC;
                end
            end
            // full store: report, clear, then handle the byte normally
            S_OVF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ovf   = 1'b1;
                    o_cmd.clear_line = 1'b1;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (i_sts.is_bs) begin
                    o_cmd.back_space = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.is_lf) begin
                    o_cmd.rd_last = 1'b1;
                    n_state = S_END_CMP;
                end else begin
                    o_cmd.write_byte = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_END_CMP: begin
                o_cmd.load_cmp = 1'b1;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (i_sts.out_free) begin
                    if (i_sts.no_match) begin
                        o_cmd.emit_unknown = 1'b1;
                        o_cmd.clear_line   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_head = 1'b1;
                        if (i_sts.hdr_last) begin
                            o_cmd.clear_line = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_ARG_RD;
                        end
                    end
                end
            end
            S_ARG_RD: begin
                o_cmd.rd_arg = 1'b1;
                n_state = S_ARG_OUT;
            end
            S_ARG_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_arg = 1'b1;
                    if (i_sts.arg_last) begin
                        o_cmd.clear_line = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ARG_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/atclr_dp.sv -----
module atclr_dp
    import atclr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output t_status           o_status,
    output logic [SLOT_W-1:0] o_slot_index,
    output logic [7:0]        o_arg_byte,
    output logic              o_arg_valid,
    output logic              o_last
);

    logic [CFG_W-1:0]  r_slot [SLOT_REGS];
    logic [7:0]        r_mem  [LINE_BYTES];
    logic [7:0]        r_name [NAME_BYTES];
    logic [7:0]        r_byte;
    logic [7:0]        r_rd_data;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_mark;
    logic [CNT_W-1:0]  r_end;
    logic [CNT_W-1:0]  r_ptr;
    logic [NAME_SLOTS-1:0] r_match;

    logic              r_out_valid;
    t_status           r_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic [7:0]        r_arg_byte;
    logic              r_arg_valid;
    logic              r_last;

    logic [CNT_W-1:0]  w_cnt_m1;
    logic [CNT_W-1:0]  w_end;
    logic [CNT_W-1:0]  w_name_len;
    logic [CNT_W-1:0]  w_first;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [LEN_W-1:0]  w_len  [NAME_SLOTS];
    logic [NAME_SLOTS-1:0] w_same;
    logic [NAME_SLOTS-1:0] w_match;
    logic [SLOT_W-1:0] w_slot;
    logic              w_out_free;
    logic              w_emit;

    // Name slot registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_REGS; s++) begin
                r_slot[s] <= (s == 0) ? SLOT0_RESET : '0;
            end
        end else if (i_cfg_we && (i_cfg_index < IDX_W'(SLOT_REGS))) begin
            r_slot[i_cfg_index] <= i_cfg_data;
        end
    end

    // Input byte holding register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_byte <= i_rx_byte;
        end
    end

    // Line store write and registered read
    assign w_cnt_m1  = r_count - CNT_W'(1);
    assign w_rd_addr = i_cmd.rd_last ? w_cnt_m1[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_last || i_cmd.rd_arg) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Copy of the first name bytes for the slot compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte && (r_count < CNT_W'(NAME_BYTES))) begin
            r_name[r_count[NB_W-1:0]] <= r_byte;
        end
    end

    // Fill count and argument mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mark  <= '0;
        end else if (i_cmd.clear_line) begin
            r_count <= '0;
            r_mark  <= '0;
        end else if (i_cmd.write_byte) begin
            r_count <= r_count + CNT_W'(1);
            if (r_byte == CH_EQ) begin
                r_mark <= r_count + CNT_W'(1);
            end
        end else if (i_cmd.back_space && (r_count != '0)) begin
            r_count <= w_cnt_m1;
            // deleting the marking equals sign drops the mark
            if (r_mark == r_count) begin
                r_mark <= '0;
            end
        end
    end

    // Line end: trailing CR, name length, argument start
    assign w_end      = ((r_count != '0) && (r_rd_data == CH_CR)) ? w_cnt_m1 : r_count;
    assign w_name_len = (r_mark != '0) ? (r_mark - CNT_W'(1)) : w_end;
    assign w_first    = (r_mark != '0) ? r_mark : w_end;

    // Per-slot exact compare
    always_comb begin
        for (int s = 0; s < NAME_SLOTS; s++) begin
            w_len[s] = LEN_W'(NAME_BYTES);
            for (int k = NAME_BYTES - 1; k >= 0; k--) begin
                if (r_slot[s][8*k +: 8] == 8'h00) begin
                    w_len[s] = LEN_W'(k);
                end
            end
            w_same[s] = 1'b1;
            for (int k = 0; k < NAME_BYTES; k++) begin
                if ((CNT_W'(k) < w_name_len) && (r_slot[s][8*k +: 8] != r_name[k])) begin
                    w_same[s] = 1'b0;
                end
            end
            w_match[s] = (r_slot[s] != '0) && (CNT_W'(w_len[s]) == w_name_len) && w_same[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmp) begin
            r_end   <= w_end;
            r_ptr   <= w_first;
            r_match <= w_match;
        end else if (i_cmd.emit_arg) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
    end

    // Lowest matching slot wins
    always_comb begin
        w_slot = '0;
        for (int s = NAME_SLOTS - 1; s >= 0; s--) begin
            if (r_match[s]) begin
                w_slot = SLOT_W'(s);
            end
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_emit     = i_cmd.emit_ovf || i_cmd.emit_unknown || i_cmd.emit_head
                        || i_cmd.emit_arg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ovf) begin
            r_status    <= ST_OVERFLOW;
            r_out_slot  <= '0;
            r_arg_byte  <= '0;
            r_arg_valid <= 1'b0;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_unknown) begin
            r_status    <= ST_UNKNOWN;
            r_out_slot  <= '0;
            r_arg_byte  <= '0;
            r_arg_valid <= 1'b0;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_head) begin
            r_status    <= ST_MATCH;
            r_out_slot  <= w_slot;
            r_arg_byte  <= '0;
            r_arg_valid <= 1'b0;
            r_last      <= o_sts.hdr_last;
        end else if (i_cmd.emit_arg) begin
            // slot index stays from the header
            r_status    <= ST_MATCH;
            r_arg_byte  <= r_rd_data;
            r_arg_valid <= 1'b1;
            r_last      <= o_sts.arg_last;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.full     = (r_count == CNT_W'(LINE_BYTES));
        o_sts.is_bs    = (r_byte == CH_BS);
        o_sts.is_lf    = (r_byte == CH_LF);
        o_sts.out_free = w_out_free;
        o_sts.no_match = (r_match == '0);
        o_sts.hdr_last = (r_ptr >= r_end);
        o_sts.arg_last = ((r_ptr + CNT_W'(1)) == r_end);
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_out_slot;
    assign o_arg_byte   = r_arg_byte;
    assign o_arg_valid  = r_arg_valid;
    assign o_last       = r_last;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LINE_BYTES))
        else $error("fill count beyond line size");

    a_mark_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark <= r_count)
        else $error("argument mark past end of line");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result loaded over a pending transfer");

    a_arg_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_arg_valid) |-> (r_status == ST_MATCH))
        else $error("argument byte without matched command");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_byte |-> (r_count < CNT_W'(LINE_BYTES)))
        else $error("write into full line store");

endmodule
